@@ rtl/jofs_pkg.sv @@
// Shared types and constants for the JSON object field scanner.
`timescale 1ns / 1ps
package jofs_pkg;

  typedef enum logic [2:0] {
    K_KEYBYTE = 3'd0,
    K_KEYEND  = 3'd1,
    K_VALBYTE = 3'd2,
    K_VALEND  = 3'd3,
    K_ACCEPT  = 3'd4,
    K_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_KEYSTART = 4'd1,
    PH_KEY      = 4'd2,
    PH_COLON    = 4'd3,
    PH_VALSTART = 4'd4,
    PH_VSTR     = 4'd5,
    PH_CONT     = 4'd6,
    PH_SCALAR   = 4'd7,
    PH_AFTERVAL = 4'd8,
    PH_TRAIL    = 4'd9
  } phase_t;

  localparam logic [3:0] E_EXPECT_OBJ  = 4'd0;
  localparam logic [3:0] E_EXPECT_KEY  = 4'd1;
  localparam logic [3:0] E_BAD_ESC     = 4'd2;
  localparam logic [3:0] E_TRUNC_ESC   = 4'd3;
  localparam logic [3:0] E_UNTERM_STR  = 4'd4;
  localparam logic [3:0] E_EXPECT_COL  = 4'd5;
  localparam logic [3:0] E_MISSING_VAL = 4'd6;
  localparam logic [3:0] E_UNTERM_CONT = 4'd7;
  localparam logic [3:0] E_EXPECT_SEP  = 4'd8;
  localparam logic [3:0] E_TRAILING    = 4'd9;
  localparam logic [3:0] E_WS_OVERFLOW = 4'd10;
  localparam logic [3:0] E_DEPTH_OVF   = 4'd11;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] error_code;
    logic       run_end;
  } out_item_t;

  // Front-to-back command: the byte plus its classification.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       is_ws;
    logic [8:0] unesc;  // bit 8 set: unsupported escape
  } cmd_t;

  function automatic logic ws_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [8:0] unescape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = 9'h022;
      8'h5C:   r = 9'h05C;
      8'h2F:   r = 9'h02F;
      8'h62:   r = 9'h008;
      8'h66:   r = 9'h00C;
      8'h6E:   r = 9'h00A;
      8'h72:   r = 9'h00D;
      8'h74:   r = 9'h009;
      default: r = 9'h100;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/jofs_front.sv @@
// Front stage: accepts bytes, classifies them, and queues commands.
`timescale 1ns / 1ps
module jofs_front
  import jofs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  // two-entry queue
  cmd_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       cls;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    cls.text_byte  = in_item.text_byte;
    cls.final_byte = in_item.final_byte;
    cls.is_ws      = ws_char(in_item.text_byte);
    cls.unesc      = unescape(in_item.text_byte);
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ rtl/jofs_back.sv @@
// Back stage: scanner state machine, pending whitespace buffer, result register.
`timescale 1ns / 1ps
module jofs_back
  import jofs_pkg::*;
#(
  parameter int PENDING_DEPTH = 16,
  parameter int NEST_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      empty,
  output out_item_t out_item,
  input  logic      pop
);

  localparam int PW = $clog2(PENDING_DEPTH + 1);
  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // byte work: emits up to three results (byte/end/error, value end, accept/error)
  phase_t             phase, phase_next;
  logic               esc, esc_next;
  logic               istr, istr_next;
  logic               iesc, iesc_next;
  logic               sq, sq_next;
  logic [NEST_BITS-1:0] depth, depth_next;
  logic [PW-1:0]      scount, scount_next;
  logic               failed, failed_next;

  logic [7:0]         store [PENDING_DEPTH];
  logic               st_we;
  logic [PW-1:0]      flush_idx;
  logic               flushing, flushing_next;
  logic [PW-1:0]      flush_idx_next;
  logic [7:0]         flush_data;  // registered read of the pending buffer
  logic               rd_en;
  logic [PW-1:0]      rd_idx;

  // results of the current byte, in order
  logic               r0_v, r1_v, r2_v;
  out_item_t          r0, r1, r2;
  logic [1:0]         slot;
  logic               busy;  // holding results of a byte
  out_item_t          hr0, hr1, hr2;
  logic               hv1, hv2;

  logic [7:0]         c;
  logic               fin;
  logic               open_c, close_c;
  logic               do_reset;
  logic               out_v;
  logic               load_out;
  out_item_t          out_next;

  assign c   = cmd.text_byte;
  assign fin = cmd.final_byte;

  function automatic out_item_t mk(input kind_t k, input logic [7:0] d,
                                   input logic [3:0] e);
    out_item_t o;
    o.kind = k; o.data = d; o.error_code = e; o.run_end = 1'b0;
    return o;
  endfunction

  assign open_c  = sq ? (c == CH_LBRACK) : (c == CH_LBRACE);
  assign close_c = sq ? (c == CH_RBRACK) : (c == CH_RBRACE);

  // output register can load when empty or being drained
  assign empty    = !out_v;
  assign load_out = !out_v || pop;

  // buffer read: entry 0 when a flush starts, then the next entry per load
  assign rd_idx = flushing ? (flush_idx + PW'(1)) : '0;
  assign rd_en  = flushing ? (load_out && (flush_idx != scount - PW'(1)))
                           : flushing_next;

  // Stage A: when idle take a command; if scalar with pending spaces and
  // non-ws non-terminator, first flush store one entry per cycle while the result register can load.
  always_comb begin
    phase_next     = phase;
    esc_next       = esc;
    istr_next      = istr;
    iesc_next      = iesc;
    sq_next        = sq;
    depth_next     = depth;
    scount_next    = scount;
    failed_next    = failed;
    st_we          = 1'b0;
    flushing_next  = flushing;
    flush_idx_next = flush_idx;
    r0_v = 1'b0; r1_v = 1'b0; r2_v = 1'b0;
    r0 = mk(K_KEYBYTE, 8'd0, 4'd0);
    r1 = r0; r2 = r0;
    do_reset = 1'b0;
    cmd_take = 1'b0;
    if (!busy && cmd_valid && !flushing) begin
      if (!failed && phase == PH_SCALAR && !cmd.is_ws && c != CH_COMMA &&
          c != CH_RBRACE && scount != '0) begin
        flushing_next  = 1'b1;
        flush_idx_next = '0;
      end else begin
        cmd_take = 1'b1;
        if (!failed) begin
          case (phase)
            PH_START: begin
              if (!cmd.is_ws) begin
                if (c == CH_LBRACE) phase_next = PH_KEYSTART;
                else begin r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_EXPECT_OBJ);
                  failed_next = 1'b1; end
              end
            end
            PH_KEYSTART: begin
              if (!cmd.is_ws) begin
                if (c == CH_RBRACE) phase_next = PH_TRAIL;
                else if (c == CH_QUOTE) phase_next = PH_KEY;
                else begin r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_EXPECT_KEY);
                  failed_next = 1'b1; end
              end
            end
            PH_KEY, PH_VSTR: begin
              if (esc) begin
                esc_next = 1'b0;
                r0_v = 1'b1;
                if (cmd.unesc[8]) begin
                  r0 = mk(K_ERROR, 8'd0, E_BAD_ESC); failed_next = 1'b1;
                end else
                  r0 = mk(phase == PH_KEY ? K_KEYBYTE : K_VALBYTE,
                          cmd.unesc[7:0], 4'd0);
              end else if (c == CH_QUOTE) begin
                r0_v = 1'b1;
                r0 = mk(phase == PH_KEY ? K_KEYEND : K_VALEND, 8'd0, 4'd0);
                phase_next = (phase == PH_KEY) ? PH_COLON : PH_AFTERVAL;
              end else if (c == CH_BSLASH) esc_next = 1'b1;
              else begin
                r0_v = 1'b1;
                r0 = mk(phase == PH_KEY ? K_KEYBYTE : K_VALBYTE, c, 4'd0);
              end
            end
            PH_COLON: begin
              if (!cmd.is_ws) begin
                if (c == CH_COLON) phase_next = PH_VALSTART;
                else begin r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_EXPECT_COL);
                  failed_next = 1'b1; end
              end
            end
            PH_VALSTART: begin
              if (!cmd.is_ws) begin
                if (c == CH_QUOTE) phase_next = PH_VSTR;
                else if (c == CH_LBRACK || c == CH_LBRACE) begin
                  phase_next = PH_CONT;
                  sq_next    = (c == CH_LBRACK);
                  depth_next = NEST_BITS'(1);
                  istr_next  = 1'b0;
                  iesc_next  = 1'b0;
                  r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
                end else if (c == CH_COMMA || c == CH_RBRACE) begin
                  scount_next = '0;
                  phase_next  = (c == CH_COMMA) ? PH_KEYSTART : PH_TRAIL;
                  r0_v = 1'b1; r0 = mk(K_VALEND, 8'd0, 4'd0);
                end else begin
                  phase_next  = PH_SCALAR;
                  scount_next = '0;
                  r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
                end
              end
            end
            PH_CONT: begin
              if (istr) begin
                if (iesc) iesc_next = 1'b0;
                else if (c == CH_BSLASH) iesc_next = 1'b1;
                else if (c == CH_QUOTE) istr_next = 1'b0;
                r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
              end else if (c == CH_QUOTE) begin
                istr_next = 1'b1;
                r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
              end else if (open_c) begin
                r0_v = 1'b1;
                if (&depth) begin
                  r0 = mk(K_ERROR, 8'd0, E_DEPTH_OVF); failed_next = 1'b1;
                end else begin
                  depth_next = depth + NEST_BITS'(1);
                  r0 = mk(K_VALBYTE, c, 4'd0);
                end
              end else begin
                r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
                if (close_c) begin
                  depth_next = depth - NEST_BITS'(1);
                  if (depth == NEST_BITS'(1)) begin
                    phase_next = PH_AFTERVAL;
                    r1_v = 1'b1; r1 = mk(K_VALEND, 8'd0, 4'd0);
                  end
                end
              end
            end
            PH_SCALAR: begin
              if (c == CH_COMMA || c == CH_RBRACE) begin
                scount_next = '0;
                phase_next  = (c == CH_COMMA) ? PH_KEYSTART : PH_TRAIL;
                r0_v = 1'b1; r0 = mk(K_VALEND, 8'd0, 4'd0);
              end else if (cmd.is_ws) begin
                if (scount == PW'(PENDING_DEPTH)) begin
                  r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_WS_OVERFLOW);
                  failed_next = 1'b1;
                end else begin
                  st_we       = 1'b1;
                  scount_next = scount + PW'(1);
                end
              end else begin
                scount_next = '0;
                r0_v = 1'b1; r0 = mk(K_VALBYTE, c, 4'd0);
              end
            end
            PH_AFTERVAL: begin
              if (!cmd.is_ws) begin
                if (c == CH_COMMA) phase_next = PH_KEYSTART;
                else if (c == CH_RBRACE) phase_next = PH_TRAIL;
                else begin r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_EXPECT_SEP);
                  failed_next = 1'b1; end
              end
            end
            default: begin
              if (!cmd.is_ws) begin
                r0_v = 1'b1; r0 = mk(K_ERROR, 8'd0, E_TRAILING);
                failed_next = 1'b1;
              end
            end
          endcase
        end
        if (fin) begin
          do_reset = 1'b1;
          if (!failed_next) begin
            r2_v = 1'b1;
            case (phase_next)
              PH_TRAIL:            r2 = mk(K_ACCEPT, 8'd0, 4'd0);
              PH_START:            r2 = mk(K_ERROR, 8'd0, E_EXPECT_OBJ);
              PH_KEYSTART:         r2 = mk(K_ERROR, 8'd0, E_EXPECT_KEY);
              PH_KEY, PH_VSTR:     r2 = mk(K_ERROR, 8'd0,
                                           esc_next ? E_TRUNC_ESC : E_UNTERM_STR);
              PH_COLON:            r2 = mk(K_ERROR, 8'd0, E_EXPECT_COL);
              PH_VALSTART:         r2 = mk(K_ERROR, 8'd0, E_MISSING_VAL);
              PH_CONT:             r2 = mk(K_ERROR, 8'd0, E_UNTERM_CONT);
              default:             r2 = mk(K_ERROR, 8'd0, E_EXPECT_SEP);
            endcase
          end
        end
      end
    end
  end

  // result sequencing: flush entries, then held byte results
  always_comb begin
    out_next = hr0;
    if (flushing) begin
      out_next = mk(K_VALBYTE, flush_data, 4'd0);
    end else if (busy) begin
      case (slot)
        2'd0:    out_next = hr0;
        2'd1:    out_next = hr1;
        default: out_next = hr2;
      endcase
      out_next.run_end = (slot == 2'd0) ? !(hv1 || hv2) :
                         (slot == 2'd1) ? !hv2 : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) store[scount[IW-1:0]] <= c;
    if (rd_en) flush_data <= store[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START; esc <= 1'b0; istr <= 1'b0; iesc <= 1'b0; sq <= 1'b0;
      depth <= '0; scount <= '0; failed <= 1'b0;
      flushing <= 1'b0; flush_idx <= '0;
      busy <= 1'b0; slot <= 2'd0; out_v <= 1'b0;
      hv1 <= 1'b0; hv2 <= 1'b0;
    end else begin
      if (out_v && pop) out_v <= 1'b0;
      if (flushing) begin
        if (load_out) begin
          out_item <= out_next;
          out_v    <= 1'b1;
          if (flush_idx == scount - PW'(1)) begin
            flushing <= 1'b0;
            scount   <= '0;
          end else flush_idx <= flush_idx + PW'(1);
        end
      end else if (busy) begin
        if (load_out) begin
          out_item <= out_next;
          out_v    <= 1'b1;
          if (out_next.run_end) busy <= 1'b0;
          else if (slot == 2'd0) slot <= hv1 ? 2'd1 : 2'd2;
          else slot <= 2'd2;
        end
      end else begin
        flushing  <= flushing_next;
        flush_idx <= flush_idx_next;
        if (cmd_take) begin
          if (do_reset) begin
            phase <= PH_START; esc <= 1'b0; istr <= 1'b0; iesc <= 1'b0;
            sq <= 1'b0; depth <= '0; scount <= '0; failed <= 1'b0;
          end else begin
            phase <= phase_next; esc <= esc_next; istr <= istr_next;
            iesc <= iesc_next; sq <= sq_next; depth <= depth_next;
            scount <= scount_next; failed <= failed_next;
          end
          hr0 <= r0; hr1 <= r1; hr2 <= r2;
          hv1 <= r1_v; hv2 <= r2_v;
          if (r0_v || r1_v || r2_v) begin
            busy <= 1'b1;
            slot <= r0_v ? 2'd0 : (r1_v ? 2'd1 : 2'd2);
          end
        end
      end
    end
  end

endmodule

@@ rtl/json_object_field_scanner.sv @@
// Top level of the JSON object field scanner.
`timescale 1ns / 1ps
// Streaming scanner for one flat JSON object, one byte per transaction.
// Input channel: push/full with {text_byte, final_byte}; final_byte marks
// the last byte of a text, which yields accept or an error (unless an error
// came before), and the scanner returns to its reset state for the next text.
// Result channel: empty/pop with {kind, data, error_code, run_end}; run_end
// flags the last result caused by one input byte.
// Structure: a front stage classifies bytes (whitespace, escape decode)
// into a two-entry queue; a back stage runs the phase machine, keeps the
// pending whitespace buffer and feeds a one-entry result register.
// Pacing: the back stage takes no new byte until all results of the last
// one are loaded; a scalar byte that follows withheld whitespace first
// flushes that buffer: a setup step, then one entry per cycle while the
// result register can load (up to PENDING_DEPTH entries).
// When the receiver stops popping, the result register holds, the back
// stage stalls, the queue fills and full rises.
// Reset (rst, synchronous) clears the queue, the result register and all
// scanner state; the whitespace buffer contents are not cleared.
module json_object_field_scanner
  import jofs_pkg::*;
#(
  parameter int PENDING_DEPTH = 16,
  parameter int NEST_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  jofs_front u_front (
    .clk(clk), .rst(rst), .push(push), .in_item(in_item), .full(full),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  jofs_back #(
    .PENDING_DEPTH(PENDING_DEPTH), .NEST_BITS(NEST_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .empty(empty), .out_item(out_item), .pop(pop)
  );

endmodule
